[design/udp_chunk_header_generator_macros.svh]
// ----------------------------------------------------------------------------
// UDP chunk header generator assertion macros
// Concurrent assertion wrappers, left empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef UDP_CHUNK_HEADER_GENERATOR_MACROS_SVH
`define UDP_CHUNK_HEADER_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define UCHG_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("udp chunk header generator check failed");
`define UCHG_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("udp chunk header generator check failed");
`else
`define UCHG_ASSERT(label, clk, rst_n, prop)
`define UCHG_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[design/uchg_pkg.sv]
// ----------------------------------------------------------------------------
// UDP chunk header generator package
// Word types, register indexes and fixed header constants.
// ----------------------------------------------------------------------------
package uchg_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] payload_byte;
  } in_word_t;

  typedef struct packed {
    logic [10:0] ip_total_length;
    logic [15:0] ip_header_checksum;
    logic [10:0] udp_length;
    logic [15:0] udp_checksum;
    logic [31:0] chunk_number;
    logic [10:0] payload_length;
    logic        end_marker;
    logic        last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [10:0] plen;
    logic [26:0] psum;
    logic [31:0] number;
    logic        is_end;
    logic        last;
  } desc_t;

  typedef enum logic [1:0] {
    REG_SOURCE_ADDRESS      = 2'd0,
    REG_DESTINATION_ADDRESS = 2'd1,
    REG_DESTINATION_PORT    = 2'd2,
    REG_SOURCE_PORT         = 2'd3
  } cfg_index_t;

  localparam logic        CMD_BYTE        = 1'b0;
  localparam logic        CMD_END         = 1'b1;
  localparam logic [15:0] SOURCE_PORT_RST = 16'd12345;
  localparam logic [31:0] END_NUMBER      = 32'hFFFF_FFFF;
  localparam logic [15:0] IP_VER_IHL_TOS  = 16'h4500;
  localparam logic [15:0] IP_TTL_PROTO    = 16'h4011;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;
  localparam logic [10:0] IP_HDR_OVERHEAD = 11'd32;
  localparam logic [10:0] UDP_OVERHEAD    = 11'd12;
  localparam int          FIFO_DEPTH      = 4;

endpackage

[design/udp_chunk_header_generator.sv]
// A descriptor is written into the descriptor queue when its word is accepted, then moves to the output register.
// Throughput: one input word per cycle while the queue has room; an end word with a partial chunk yields two
// descriptors, written in the same cycle into a four-entry descriptor queue.
// The queue accepts a word whenever it has room for two descriptors.
// Reset is synchronous and active low: chunk state and counter clear, registers
// take their reset values and the queue empties.
// ----------------------------------------------------------------------------
// UDP chunk header generator
// Cuts a byte stream into chunks and emits IPv4/UDP header descriptors.
// ----------------------------------------------------------------------------
`include "udp_chunk_header_generator_macros.svh"

module udp_chunk_header_generator
  import uchg_pkg::*;
#(
  parameter int CHUNK_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [31:0] source_address_r;
  logic [31:0] destination_address_r;
  logic [15:0] destination_port_r;
  logic [15:0] source_port_r;
  logic [17:0] addr_sum_r;
  logic [19:0] udp_base_r;

  logic [25:0] running_sum_r, running_sum_nxt;
  logic [10:0] byte_count_r, byte_count_nxt;
  logic [7:0]  held_high_byte_r, held_high_byte_nxt;
  logic [31:0] chunk_counter_r, chunk_counter_nxt;

  desc_t             fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  desc_t       d0, d1;
  logic        push0, push1, pop;
  logic        in_fire;
  logic [10:0] cnt_inc;
  logic [25:0] sum_upd;
  logic [26:0] psum_now;

  desc_t       head;
  logic [10:0] ip_len, udp_len;
  logic [18:0] ip_acc;
  logic [16:0] ip_f1;
  logic [15:0] ip_f2;
  logic [27:0] udp_acc;
  logic [16:0] udp_f1;
  logic [15:0] udp_f2, udp_ck;

  out_word_t   out_r, out_nxt;
  logic        out_valid_r;

  assign in_ready = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_address_r      <= '0;
      destination_address_r <= '0;
      destination_port_r    <= '0;
      source_port_r         <= SOURCE_PORT_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        REG_SOURCE_ADDRESS:      source_address_r      <= cfg_data;
        REG_DESTINATION_ADDRESS: destination_address_r <= cfg_data;
        REG_DESTINATION_PORT:    destination_port_r    <= cfg_data[15:0];
        REG_SOURCE_PORT:         source_port_r         <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Header sums that depend only on configuration are kept precomputed.
  always_ff @(posedge clk) begin
    addr_sum_r <= 18'(source_address_r[31:16]) + 18'(source_address_r[15:0])
                + 18'(destination_address_r[31:16]) + 18'(destination_address_r[15:0]);
    udp_base_r <= 20'(source_address_r[31:16]) + 20'(source_address_r[15:0])
                + 20'(destination_address_r[31:16]) + 20'(destination_address_r[15:0])
                + 20'(PROTO_UDP) + 20'(source_port_r) + 20'(destination_port_r);
  end

  always_comb begin
    running_sum_nxt    = running_sum_r;
    byte_count_nxt     = byte_count_r;
    held_high_byte_nxt = held_high_byte_r;
    chunk_counter_nxt  = chunk_counter_r;
    push0   = 1'b0;
    push1   = 1'b0;
    d0      = '0;
    d1      = '0;
    cnt_inc = byte_count_r + 11'd1;
    sum_upd = running_sum_r + 26'({held_high_byte_r, in_data.payload_byte});
    psum_now = 27'(running_sum_r)
             + (byte_count_r[0] ? 27'({held_high_byte_r, 8'h00}) : 27'd0);
    if (in_fire) begin
      if (in_data.command == CMD_BYTE) begin
        if (!byte_count_r[0]) begin
          held_high_byte_nxt = in_data.payload_byte;
        end else begin
          running_sum_nxt    = sum_upd;
          held_high_byte_nxt = '0;
        end
        byte_count_nxt = cnt_inc;
        if (cnt_inc >= 11'(CHUNK_BYTES)) begin
          push0     = 1'b1;
          d0.plen   = cnt_inc;
          d0.psum   = 27'(running_sum_nxt)
                    + (cnt_inc[0] ? 27'({held_high_byte_nxt, 8'h00}) : 27'd0);
          d0.number = chunk_counter_r;
          d0.is_end = 1'b0;
          d0.last   = 1'b1;
          chunk_counter_nxt  = chunk_counter_r + 32'd1;
          running_sum_nxt    = '0;
          byte_count_nxt     = '0;
          held_high_byte_nxt = '0;
        end
      end else begin
        if (byte_count_r != 11'd0) begin
          push0     = 1'b1;
          d0.plen   = byte_count_r;
          d0.psum   = psum_now;
          d0.number = chunk_counter_r;
          d0.is_end = 1'b0;
          d0.last   = 1'b0;
          push1     = 1'b1;
          d1.number = END_NUMBER;
          d1.is_end = 1'b1;
          d1.last   = 1'b1;
        end else begin
          push0     = 1'b1;
          d0.number = END_NUMBER;
          d0.is_end = 1'b1;
          d0.last   = 1'b1;
        end
        chunk_counter_nxt  = '0;
        running_sum_nxt    = '0;
        byte_count_nxt     = '0;
        held_high_byte_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r    <= '0;
      byte_count_r     <= '0;
      held_high_byte_r <= '0;
      chunk_counter_r  <= '0;
    end else begin
      running_sum_r    <= running_sum_nxt;
      byte_count_r     <= byte_count_nxt;
      held_high_byte_r <= held_high_byte_nxt;
      chunk_counter_r  <= chunk_counter_nxt;
    end
  end

  assign head      = fifo_r[rd_ptr_r];
  assign pop       = (count_r != '0) && (!out_valid_r || out_ready);
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push0) + PTR_W'(push1);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      fifo_r[wr_ptr_r] <= d0;
    end
    if (push1) begin
      fifo_r[wr_ptr_p1] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_comb begin
    ip_len  = IP_HDR_OVERHEAD + head.plen;
    udp_len = UDP_OVERHEAD + head.plen;
    ip_acc  = 19'(IP_VER_IHL_TOS) + 19'(IP_TTL_PROTO) + 19'(ip_len) + 19'(addr_sum_r);
    ip_f1   = 17'(ip_acc[15:0]) + 17'(ip_acc[18:16]);
    ip_f2   = ip_f1[15:0] + 16'(ip_f1[16]);
    udp_acc = 28'(udp_base_r) + 28'({udp_len, 1'b0})
            + 28'({head.number[7:0], head.number[15:8]})
            + 28'({head.number[23:16], 8'h00})
            + 28'(head.number[31:24]) + 28'(head.psum);
    udp_f1  = 17'(udp_acc[15:0]) + 17'(udp_acc[27:16]);
    udp_f2  = udp_f1[15:0] + 16'(udp_f1[16]);
    udp_ck  = ~udp_f2;
    out_nxt.ip_total_length    = ip_len;
    out_nxt.ip_header_checksum = ~ip_f2;
    out_nxt.udp_length         = udp_len;
    out_nxt.udp_checksum       = (udp_ck == 16'd0) ? 16'hFFFF : udp_ck;
    out_nxt.chunk_number       = head.number;
    out_nxt.payload_length     = head.plen;
    out_nxt.end_marker         = head.is_end;
    out_nxt.last_of_run        = head.last;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `UCHG_ASSERT(a_queue_bound, clk, rst_n, count_r <= CNT_W'(FIFO_DEPTH))
  `UCHG_ASSERT(a_chunk_bound, clk, rst_n, byte_count_r < 11'(CHUNK_BYTES))
  `UCHG_ASSERT(a_end_clears, clk, rst_n,
    in_fire && (in_data.command == CMD_END) |=> (byte_count_r == 11'd0) && (chunk_counter_r == 32'd0))
  `UCHG_ASSERT(a_end_shape, clk, rst_n,
    out_valid_r && out_r.end_marker |-> (out_r.payload_length == 11'd0) && out_r.last_of_run)
  `UCHG_ASSERT(a_udp_nonzero, clk, rst_n, out_valid_r |-> (out_r.udp_checksum != 16'd0))

endmodule

[sim/udp_chunk_header_generator_tb.sv]
// ----------------------------------------------------------------------------
// UDP chunk header generator testbench
// Feeds images as byte words and end words into the generator. A header
// predictor, kept in step with every accepted word, supplies the expected
// descriptors. A short table of directed words comes first. Random images
// follow under four register settings and four patterns of sender idling and
// receiver stalls. One of those images is longer than a full chunk.
// ----------------------------------------------------------------------------
module udp_chunk_header_generator_tb;
  import uchg_pkg::*;

  localparam int          CHUNK_BYTES   = 1024;
  localparam int          STALL_LIMIT   = 2000;
  localparam logic [7:0]  VER_IHL       = 8'h45;
  localparam logic [7:0]  TTL_HOPS      = 8'd64;
  localparam logic [7:0]  UDP_PROTO     = 8'd17;
  localparam logic [31:0] IP_OVERHEAD   = 32'd32;
  localparam logic [31:0] UDP_OVERHEAD  = 32'd12;
  localparam logic [31:0] LAST_CHUNK_NO = 32'hFFFF_FFFF;
  localparam logic [15:0] PORT_AT_RESET = 16'd12345;

  // Descriptors worked out by hand for the register values after reset.
  localparam out_word_t END_AT_RESET =
    {11'd32, 16'h7ACE, 11'd12, 16'hCF9D, 32'hFFFF_FFFF, 11'd0, 1'b1, 1'b1};
  localparam out_word_t ZERO_SUM_CHUNK =
    {11'd34, 16'h7ACC, 11'd14, 16'hFFFF, 32'd0, 11'd2, 1'b0, 1'b0};

  typedef struct {
    in_word_t  w;
    int        n_typed;
    out_word_t exp_a;
    out_word_t exp_b;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  logic [31:0] src_ip = '0;
  logic [31:0] dst_ip = '0;
  logic [15:0] dst_port = '0;
  logic [15:0] src_port = PORT_AT_RESET;
  logic [25:0] chunk_sum = '0;
  logic [10:0] chunk_bytes = '0;
  logic [7:0]  pending_hi = '0;
  logic [31:0] chunk_no = '0;

  out_word_t header_queue [$];
  dir_row_t  dir_rows [$];
  out_word_t want_hdr;
  int        mismatch_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        quiet_cycles = 0;

  udp_chunk_header_generator #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] ones_fold(input logic [31:0] s);
    logic [31:0] t;
    t = s;
    while (t[31:16] != 16'h0000) t = {16'h0000, t[15:0]} + {16'h0000, t[31:16]};
    return t[15:0];
  endfunction

  function automatic out_word_t build_header(input logic [10:0] plen,
                                             input logic [31:0] psum,
                                             input logic [31:0] number,
                                             input logic is_end, input logic last);
    out_word_t   h;
    logic [31:0] ip_len;
    logic [31:0] udp_len;
    logic [31:0] addr_sum;
    logic [31:0] acc;
    logic [15:0] ck;
    ip_len   = 32'(plen) + IP_OVERHEAD;
    udp_len  = 32'(plen) + UDP_OVERHEAD;
    addr_sum = 32'(src_ip[31:16]) + 32'(src_ip[15:0]) + 32'(dst_ip[31:16])
             + 32'(dst_ip[15:0]);
    acc = {16'h0000, VER_IHL, 8'h00} + ip_len + {16'h0000, TTL_HOPS, UDP_PROTO} + addr_sum;
    h.ip_header_checksum = ~ones_fold(acc);
    acc = addr_sum + 32'(UDP_PROTO) + udp_len + 32'(src_port) + 32'(dst_port) + udp_len
        + {16'h0000, number[7:0], number[15:8]} + {16'h0000, number[23:16], number[31:24]}
        + psum;
    ck = ~ones_fold(acc);
    h.udp_checksum    = (ck == 16'h0000) ? 16'hFFFF : ck;
    h.ip_total_length = ip_len[10:0];
    h.udp_length      = udp_len[10:0];
    h.chunk_number    = number;
    h.payload_length  = plen;
    h.end_marker      = is_end;
    h.last_of_run     = last;
    return h;
  endfunction

  // An odd chunk length leaves a high byte waiting; it counts with a zero low byte.
  function automatic logic [31:0] padded_sum();
    return 32'(chunk_sum) + (chunk_bytes[0] ? {16'h0000, pending_hi, 8'h00} : 32'h0);
  endfunction

  task automatic track_word(input in_word_t w, output int n,
                            output out_word_t first, output out_word_t second);
    out_word_t got [2];
    n = 0;
    got[0] = '0;
    got[1] = '0;
    if (w.command == CMD_BYTE) begin
      if (!chunk_bytes[0]) begin
        pending_hi = w.payload_byte;
      end else begin
        chunk_sum  = chunk_sum + {10'h000, pending_hi, w.payload_byte};
        pending_hi = '0;
      end
      chunk_bytes = chunk_bytes + 11'd1;
      if (chunk_bytes >= CHUNK_BYTES) begin
        got[0]      = build_header(chunk_bytes, padded_sum(), chunk_no, 1'b0, 1'b1);
        n           = 1;
        chunk_no    = chunk_no + 32'd1;
        chunk_sum   = '0;
        chunk_bytes = '0;
        pending_hi  = '0;
      end
    end else begin
      if (chunk_bytes != 11'd0) begin
        got[0] = build_header(chunk_bytes, padded_sum(), chunk_no, 1'b0, 1'b0);
        n = 1;
      end
      got[n]      = build_header(11'd0, 32'd0, LAST_CHUNK_NO, 1'b1, 1'b1);
      n           = n + 1;
      chunk_sum   = '0;
      chunk_bytes = '0;
      pending_hi  = '0;
      chunk_no    = '0;
    end
    first  = got[0];
    second = got[1];
  endtask

  task automatic send_word(input in_word_t w);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic deliver(input in_word_t w);
    int        n;
    out_word_t h0;
    out_word_t h1;
    send_word(w);
    track_word(w, n, h0, h1);
    if (n > 0) header_queue.push_back(h0);
    if (n > 1) header_queue.push_back(h1);
  endtask

  task automatic program_regs(input logic [31:0] sa, input logic [31:0] da,
                              input logic [31:0] dp, input logic [31:0] sp);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SOURCE_ADDRESS;
    cfg_data  <= sa;
    @(posedge clk);
    cfg_index <= REG_DESTINATION_ADDRESS;
    cfg_data  <= da;
    @(posedge clk);
    cfg_index <= REG_DESTINATION_PORT;
    cfg_data  <= dp;
    @(posedge clk);
    cfg_index <= REG_SOURCE_PORT;
    cfg_data  <= sp;
    @(posedge clk);
    cfg_we   <= 1'b0;
    src_ip   = sa;
    dst_ip   = da;
    dst_port = dp[15:0];
    src_port = sp[15:0];
  endtask

  task automatic settle();
    while (header_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int budget,
                           input bit with_long);
    int       sent;
    int       len;
    in_word_t w;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < budget || with_long) begin
      len = with_long ? CHUNK_BYTES + $urandom_range(1, 3) : $urandom_range(0, 6);
      with_long = 1'b0;
      repeat (len) begin
        w.command      = CMD_BYTE;
        w.payload_byte = 8'($urandom_range(0, 255));
        deliver(w);
      end
      w.command      = CMD_END;
      w.payload_byte = 8'($urandom_range(0, 255));
      deliver(w);
      sent = sent + len + 1;
    end
    in_valid <= 1'b0;
    settle();
  endtask

  function automatic void add_row(input logic cmd, input logic [7:0] b, input int n,
                                  input out_word_t a, input out_word_t bb);
    dir_row_t r;
    r.w.command      = cmd;
    r.w.payload_byte = b;
    r.n_typed        = n;
    r.exp_a          = a;
    r.exp_b          = bb;
    dir_rows.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (header_queue.size() == 0) begin
        $display("%0t: descriptor with nothing expected, actual %0h", $time, out_data);
        mismatch_count++;
      end else begin
        want_hdr = header_queue.pop_front();
        check_field("ip_total_length", 32'(want_hdr.ip_total_length),
                    32'(out_data.ip_total_length));
        check_field("ip_header_checksum", 32'(want_hdr.ip_header_checksum),
                    32'(out_data.ip_header_checksum));
        check_field("udp_length", 32'(want_hdr.udp_length), 32'(out_data.udp_length));
        check_field("udp_checksum", 32'(want_hdr.udp_checksum), 32'(out_data.udp_checksum));
        check_field("chunk_number", want_hdr.chunk_number, out_data.chunk_number);
        check_field("payload_length", 32'(want_hdr.payload_length),
                    32'(out_data.payload_length));
        check_field("end_marker", 32'(want_hdr.end_marker), 32'(out_data.end_marker));
        check_field("last_of_run", 32'(want_hdr.last_of_run), 32'(out_data.last_of_run));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int        n;
    out_word_t h0;
    out_word_t h1;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_SOURCE_ADDRESS;
    cfg_data  = '0;

    // The rows with typed descriptors rely on the register values after reset.
    add_row(CMD_END,  8'h00, 1, END_AT_RESET, '0);
    add_row(CMD_BYTE, 8'hCF, 0, '0, '0);
    add_row(CMD_BYTE, 8'h99, 0, '0, '0);
    add_row(CMD_END,  8'hFF, 2, ZERO_SUM_CHUNK, END_AT_RESET);
    add_row(CMD_BYTE, 8'hFF, 0, '0, '0);
    add_row(CMD_END,  8'h00, 0, '0, '0);
    add_row(CMD_BYTE, 8'h00, 0, '0, '0);
    add_row(CMD_BYTE, 8'h00, 0, '0, '0);
    add_row(CMD_END,  8'h55, 0, '0, '0);
    add_row(CMD_BYTE, 8'hFF, 0, '0, '0);
    add_row(CMD_BYTE, 8'hFF, 0, '0, '0);
    add_row(CMD_BYTE, 8'hFF, 0, '0, '0);
    add_row(CMD_END,  8'hAA, 0, '0, '0);
    add_row(CMD_END,  8'h00, 0, '0, '0);
    add_row(CMD_END,  8'hFF, 0, '0, '0);
    add_row(CMD_BYTE, 8'h80, 0, '0, '0);
    add_row(CMD_BYTE, 8'h01, 0, '0, '0);
    add_row(CMD_BYTE, 8'h7F, 0, '0, '0);
    add_row(CMD_BYTE, 8'hFE, 0, '0, '0);
    add_row(CMD_END,  8'h00, 0, '0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].w);
      track_word(dir_rows[i].w, n, h0, h1);
      if (dir_rows[i].n_typed > 0) begin
        header_queue.push_back(dir_rows[i].exp_a);
        if (dir_rows[i].n_typed > 1) header_queue.push_back(dir_rows[i].exp_b);
      end else begin
        if (n > 0) header_queue.push_back(h0);
        if (n > 1) header_queue.push_back(h1);
      end
    end
    in_valid <= 1'b0;
    settle();

    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(0, 0, 0, 1'b1);
    program_regs(32'h0, 32'h0, 32'h0, 32'h0);
    run_phase(77, 0, 12, 1'b0);
    program_regs($urandom, $urandom, $urandom, $urandom);
    run_phase(0, 77, 12, 1'b0);
    program_regs($urandom, $urandom, $urandom, $urandom);
    run_phase(21, 21, 12, 1'b0);

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && header_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/uchg_pkg.sv
design/udp_chunk_header_generator.sv
sim/udp_chunk_header_generator_tb.sv
